// ===== hw/rtl/acms_pkg.sv =====
`timescale 1ns / 1ps

package acms_pkg;

  // Default ADC sample width.
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field and register widths.
  localparam int TICK_W     = 8;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 8;
  localparam int SCALE_W    = 8;
  localparam int SUM_W      = 20;
  localparam int MA_W       = 14;
  localparam int SHAPE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Shared divider for the two averages: 32-bit dividend, 12-bit divisor,
  // one quotient bit a cycle.
  localparam int DIV_W  = 32;
  localparam int DVS_W  = 12;
  localparam int ITER_W = $clog2(DIV_W);

  // Current conversion datapath widths.
  localparam int PN_W    = SUM_W + 1;
  localparam int MUL1_W  = PN_W + 6;
  localparam int PROD_W  = MUL1_W + SCALE_W;

  // Conversion and classification constants.
  localparam int MA_MULT     = 35;
  localparam int MA_DIV      = 4095;
  localparam int THR_NONE    = 30;
  localparam int THR_HALF    = 50;
  localparam int WIN_MARGIN  = 10;
  localparam int LEN_MAX     = 127;

  // The division by MA_DIV folds the upper bits onto the lower ones, since
  // 2**FOLD_SH is one more than MA_DIV. The running remainder fits FOLD_R_W.
  localparam int FOLD_SH  = 12;
  localparam int FOLD_R_W = DIV_W - FOLD_SH + 1;

  // Register reset values.
  localparam logic [LEN_W-1:0]   HC60_RST  = LEN_W'(83);
  localparam logic [LEN_W-1:0]   HC50_RST  = LEN_W'(100);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(20);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HC60  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HC50  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_SAMPLE = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_NONE = 2'd0,
    SHAPE_NEG  = 2'd1,
    SHAPE_POS  = 2'd2,
    SHAPE_SINE = 2'd3
  } shape_t;

  typedef enum logic {
    DSEL_POS = 1'b0,
    DSEL_NEG = 1'b1
  } dsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_P,
    ST_LOAD_N,
    ST_DIV_N,
    ST_CAP_N,
    ST_MUL_A,
    ST_MUL_B,
    ST_FOLD_1,
    ST_FOLD_2,
    ST_FOLD_3,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  setup;
    logic  accum;
    logic  div_load;
    dsel_t div_sel;
    logic  div_step;
    logic  cap_p;
    logic  cap_n;
    logic  mul_a;
    logic  mul_b;
    logic  fold_first;
    logic  fold;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic samples_le1;
    logic div_last;
  } status_t;

endpackage

// ===== hw/rtl/acms_in_if.sv =====
`timescale 1ns / 1ps

interface acms_in_if import acms_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [TICK_W-1:0]      half_cycle_ticks;
  logic [SAMPLE_BITS-1:0] zero_level;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (
    output valid, half_cycle_ticks, zero_level, sample,
    input  ready
  );

  modport sink (
    input  valid, half_cycle_ticks, zero_level, sample,
    output ready
  );
endinterface

// ===== hw/rtl/acms_out_if.sv =====
`timescale 1ns / 1ps

interface acms_out_if import acms_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MA_W-1:0]    current_ma;
  logic [SHAPE_W-1:0] wave_shape;

  modport source (
    output valid, current_ma, wave_shape,
    input  ready
  );

  modport sink (
    input  valid, current_ma, wave_shape,
    output ready
  );
endinterface

// ===== hw/rtl/ac_current_mean_and_shape_unit.sv =====
`timescale 1ns / 1ps

// AC current meter over one mains cycle. Every request is one ADC tick, and
// the block walks a repeating cycle of setup, sampling and done ticks. The
// setup tick latches the measured half-cycle length when it lies inside the
// window from half_cycle_60hz-10 to half_cycle_50hz+10 (otherwise
// half_cycle_50hz), clears both sums and drops its sample. The following
// 2*length ticks (one tick when the length is zero) add each sample's
// distance from zero_level to a positive or negative sum. The done tick
// produces the only result of the cycle: the mean rectified current in
// milliamps, (p+n)*35*amps_scale/4095 with p and n the floored averages, and
// a waveform class (none, negative only, positive only, sine). Setup and
// sampling requests are taken at once, so they can stream back to back. A
// done request keeps the block busy after it is taken, until its result is
// registered: one shared restoring divider producing one quotient bit per
// cycle runs two 32-step divisions for the two averages with a load step
// between them, then come a capture step, a multiply by 35 and then by
// amps_scale, three shift-and-add steps for the division by 4095 and the
// output load. The result sits in an output register, so further requests
// are taken while it waits; only the next done request waits for it to be
// taken.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata, and should only be written while the block is idle.

module ac_current_mean_and_shape_unit import acms_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  acms_in_if.sink               in_ch,
  acms_out_if.source            out_ch
);

  cmd_t    cmd;
  status_t status;

  // The controller owns the tick phase, the divider sequencing and the
  // handshakes; the datapath holds the configuration, sums and arithmetic.
  acms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  acms_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .half_cycle_ticks (in_ch.half_cycle_ticks),
    .zero_level       (in_ch.zero_level),
    .sample           (in_ch.sample),
    .cmd              (cmd),
    .status           (status),
    .current_ma       (out_ch.current_ma),
    .wave_shape       (out_ch.wave_shape)
  );

endmodule

// ===== hw/rtl/acms_ctrl.sv =====
`timescale 1ns / 1ps

module acms_ctrl import acms_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SETUP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd           = '0;
    cmd.div_sel   = DSEL_POS;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (phase_r)
            PH_SAMPLE: begin
              cmd.accum = 1'b1;
              if (status.samples_le1) begin
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: begin
              cmd.div_load = 1'b1;
              cmd.div_sel  = DSEL_POS;
              phase_nxt    = PH_SETUP;
              state_nxt    = ST_DIV_P;
            end
            default: begin
              // Setup tick, and the unused phase code behaves the same.
              cmd.setup = 1'b1;
              phase_nxt = PH_SAMPLE;
            end
          endcase
        end
      end
      ST_DIV_P: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_LOAD_N;
        end
      end
      ST_LOAD_N: begin
        cmd.cap_p    = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_NEG;
        state_nxt    = ST_DIV_N;
      end
      ST_DIV_N: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_CAP_N;
        end
      end
      ST_CAP_N: begin
        cmd.cap_n = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_FOLD_1;
      end
      ST_FOLD_1: begin
        cmd.fold_first = 1'b1;
        state_nxt      = ST_FOLD_2;
      end
      ST_FOLD_2: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_FOLD_3;
      end
      ST_FOLD_3: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/acms_dp.sv =====
`timescale 1ns / 1ps

module acms_dp import acms_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [TICK_W-1:0]      half_cycle_ticks,
  input  logic [SAMPLE_BITS-1:0] zero_level,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [MA_W-1:0]        current_ma,
  output logic [SHAPE_W-1:0]     wave_shape
);

  logic [LEN_W-1:0]   hc60_r, hc50_r;
  logic [SCALE_W-1:0] scale_r;

  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  left_r;
  logic [SUM_W-1:0]  pos_r, neg_r;
  logic [SUM_W-1:0]  p_r, n_r;
  logic [MUL1_W-1:0] mul1_r;
  logic [DIV_W-1:0]  prod_r;

  logic [DIV_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [ITER_W-1:0] iter_r;

  logic [FOLD_R_W-1:0] sr_r;
  logic [MA_W-1:0]     sq_r;

  logic [MA_W-1:0]    ma_r;
  logic [SHAPE_W-1:0] shape_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc60_r  <= HC60_RST;
      hc50_r  <= HC50_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HC60:  hc60_r  <= cfg_wdata[LEN_W-1:0];
        CFG_HC50:  hc50_r  <= cfg_wdata[LEN_W-1:0];
        CFG_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Acceptance window for the measured half-cycle length.
  logic [LEN_W-1:0]  win_lo;
  logic [TICK_W-1:0] hc50_ext, win_hi, hi_raw;
  logic              in_win;
  logic [LEN_W-1:0]  len_nxt;

  always_comb begin
    win_lo   = (hc60_r >= LEN_W'(WIN_MARGIN)) ? hc60_r - LEN_W'(WIN_MARGIN) : '0;
    hc50_ext = TICK_W'(hc50_r);
    hi_raw   = hc50_ext + TICK_W'(WIN_MARGIN);
    win_hi   = (hi_raw > TICK_W'(LEN_MAX)) ? TICK_W'(LEN_MAX) : hi_raw;
    in_win   = (half_cycle_ticks >= TICK_W'(win_lo)) && (half_cycle_ticks <= win_hi);
    len_nxt  = in_win ? half_cycle_ticks[LEN_W-1:0] : hc50_r;
  end

  // Rectified distance from the zero level.
  logic                   above;
  logic [SAMPLE_BITS-1:0] mag;

  assign above = sample > zero_level;
  assign mag   = above ? sample - zero_level : zero_level - sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      left_r <= '0;
      pos_r  <= '0;
      neg_r  <= '0;
    end else if (cmd.setup) begin
      len_r  <= len_nxt;
      left_r <= {len_nxt, 1'b0};
      pos_r  <= '0;
      neg_r  <= '0;
    end else if (cmd.accum) begin
      if (above) begin
        pos_r <= pos_r + SUM_W'(mag);
      end else begin
        neg_r <= neg_r + SUM_W'(mag);
      end
      left_r <= (left_r <= CNT_W'(1)) ? '0 : left_r - CNT_W'(1);
    end
  end

  assign status.samples_le1 = left_r <= CNT_W'(1);

  // Shared restoring divider, one quotient bit per cycle.
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             rem_ge;
  logic [DIV_W-1:0] div_a;
  logic [DVS_W-1:0] div_b;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_ge  = rem_sh >= {1'b0, dvs_r};
    unique case (cmd.div_sel)
      DSEL_NEG: div_a = DIV_W'(neg_r);
      default:  div_a = DIV_W'(pos_r);
    endcase
    div_b = DVS_W'({len_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r    <= div_a;
      rem_r  <= '0;
      dvs_r  <= div_b;
      iter_r <= ITER_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      q_r    <= {q_r[DIV_W-2:0], rem_ge};
      rem_r  <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  assign status.div_last = iter_r == '0;

  // Averages, with a zero half-cycle length giving zero averages.
  logic len_zero;
  assign len_zero = len_r == '0;

  always_ff @(posedge clk) begin
    if (cmd.cap_p) begin
      p_r <= len_zero ? '0 : q_r[SUM_W-1:0];
    end
    if (cmd.cap_n) begin
      n_r <= len_zero ? '0 : q_r[SUM_W-1:0];
    end
    if (cmd.mul_a) begin
      mul1_r <= MUL1_W'(PN_W'(p_r) + PN_W'(n_r)) * MUL1_W'(MA_MULT);
    end
    if (cmd.mul_b) begin
      prod_r <= DIV_W'(PROD_W'(mul1_r) * PROD_W'(scale_r));
    end
  end

  // Division of the scaled product by 4095. Writing x = a*4096 + b gives
  // x = a*4095 + (a + b), so each step adds a to the quotient and carries
  // a + b on as the remainder. Three steps bring the remainder to at most
  // 4095, and one compare fixes the last unit. Only the low MA_W quotient
  // bits are kept, which the wrapping sum gives exactly.
  logic [DIV_W-1:0]         fold_in;
  logic [DIV_W-FOLD_SH-1:0] fold_hi;
  logic [FOLD_SH-1:0]       fold_lo;
  logic [FOLD_R_W-1:0]      fold_sum;
  logic [MA_W-1:0]          sq_base;
  logic [MA_W-1:0]          ma_c;

  always_comb begin
    fold_in  = cmd.fold_first ? prod_r : DIV_W'(sr_r);
    fold_hi  = fold_in[DIV_W-1:FOLD_SH];
    fold_lo  = fold_in[FOLD_SH-1:0];
    fold_sum = FOLD_R_W'(fold_hi) + FOLD_R_W'(fold_lo);
    sq_base  = cmd.fold_first ? '0 : sq_r;
    ma_c     = sq_r + MA_W'(sr_r >= FOLD_R_W'(MA_DIV));
  end

  always_ff @(posedge clk) begin
    if (cmd.fold_first || cmd.fold) begin
      sr_r <= fold_sum;
      sq_r <= sq_base + MA_W'(fold_hi);
    end
  end

  // Waveform class and result register.
  shape_t shape_c;

  always_comb begin
    priority if (p_r < SUM_W'(THR_NONE) && n_r < SUM_W'(THR_NONE)) begin
      shape_c = SHAPE_NONE;
    end else if (p_r < SUM_W'(THR_HALF)) begin
      shape_c = SHAPE_NEG;
    end else if (n_r < SUM_W'(THR_HALF)) begin
      shape_c = SHAPE_POS;
    end else begin
      shape_c = SHAPE_SINE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ma_r    <= ma_c;
      shape_r <= shape_c;
    end
  end

  assign current_ma = ma_r;
  assign wave_shape = shape_r;

endmodule
